// ----- rtl/htca_pkg.sv -----
// Shared types and constants for the heating curve table block.
// No dependencies; every other file imports this package.
`default_nettype none

package htca_pkg;

  localparam int TEMP_W = 12;
  localparam int BYTE_W = 8;
  localparam int PIDX_W = 5;
  localparam int CFG_IW = 2;

  // Shared divider sizing: numerator, divisor and quotient widths
  localparam int DIV_NW = 32;
  localparam int DIV_DW = 22;
  localparam int DIV_QW = 12;

  // Request kinds
  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_BEND   = 2'd1;
  localparam logic [1:0] KIND_ADAPT  = 2'd2;
  localparam logic [1:0] KIND_FILL   = 2'd3;

  // Register indexes
  localparam logic [CFG_IW-1:0] CFG_OUTSIDE_LOW  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_OUTSIDE_HIGH = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_SUPPLY_LOW   = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_SUPPLY_HIGH  = 2'd3;

  // Register reset values
  localparam logic signed [TEMP_W-1:0] OUTSIDE_LOW_RST  = -12'sd320;
  localparam logic signed [TEMP_W-1:0] OUTSIDE_HIGH_RST = 12'sd320;
  localparam logic signed [TEMP_W-1:0] SUPPLY_LOW_RST   = 12'sd320;
  localparam logic signed [TEMP_W-1:0] SUPPLY_HIGH_RST  = 12'sd1120;

  // Value of a curve point that was never written
  localparam logic [BYTE_W-1:0] CURVE_RST = 8'd1;
  localparam logic [BYTE_W-1:0] BYTE_MAX  = 8'd255;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [TEMP_W-1:0] outside_temp;
    logic signed [TEMP_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] supply_temp;
    logic [PIDX_W-1:0]        point_index;
    logic [BYTE_W-1:0]        stored_byte;
  } out_beat_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              sat;
    logic [DIV_QW-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/htca_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle, with saturation flag.
// Depends on htca_pkg for the request and response structs.
`default_nettype none

module htca_div import htca_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int DS_W  = DIV_DW + DIV_QW - 1;
  localparam int LIM_W = DIV_DW + DIV_QW;
  localparam int CNT_W = $clog2(DIV_QW);

  logic [DIV_NW-1:0] rem_r, rem_nxt;
  logic [DS_W-1:0]   ds_r, ds_nxt;
  logic [DIV_QW-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              sat_r, sat_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [DS_W-1:0]   rem_x;
  logic [DS_W-1:0]   rem_diff;
  logic              fits;
  logic              over;

  // Quotient does not fit when num >= den * 2^QW
  assign over = {{(LIM_W-DIV_NW){1'b0}}, req.num} >= {req.den, {DIV_QW{1'b0}}};

  assign rem_x    = {{(DS_W-DIV_NW){1'b0}}, rem_r};
  assign fits     = rem_x >= ds_r;
  assign rem_diff = rem_x - ds_r;

  // Load on start, then one trial subtract per cycle
  always_comb begin
    rem_nxt  = rem_r;
    ds_nxt   = ds_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    sat_nxt  = sat_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.num;
      ds_nxt   = {req.den, {(DIV_QW-1){1'b0}}};
      quo_nxt  = '0;
      cnt_nxt  = CNT_W'(DIV_QW - 1);
      sat_nxt  = over;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = rem_diff[DIV_NW-1:0];
      end
      quo_nxt = {quo_r[DIV_QW-2:0], fits};
      ds_nxt  = ds_r >> 1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    ds_r  <= ds_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    sat_r <= sat_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.sat  = sat_r;
  assign rsp.quo  = quo_r;

endmodule

`default_nettype wire

// ----- rtl/htca_mem.sv -----
// Curve point store: one write and one registered read port, valid bit per entry.
// Depends on htca_pkg for byte width and the reset value of a point.
`default_nettype none

module htca_mem import htca_pkg::*; #(
  parameter int POINTS = 32,
  parameter int IW     = 5
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire logic [IW-1:0]     rd_addr,
  input  wire logic              wr_en,
  input  wire logic [IW-1:0]     wr_addr,
  input  wire logic [BYTE_W-1:0] wr_data,
  output logic      [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem_r [POINTS];
  logic [POINTS-1:0] vld_r;
  logic [BYTE_W-1:0] q_r;
  logic              qv_r;

  // Storage array and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem_r[rd_addr];
    end
  end

  // Mark entries written since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        qv_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = qv_r ? q_r : CURVE_RST;

endmodule

`default_nettype wire

// ----- rtl/heating_curve_table_adapt.sv -----
// Heating curve table with bend, adapt and fill; one request in flight at a time.
// Lookup selects a point in the shared divider, then reads it and converts the byte
// to a temperature; selection skips the divider when the outside temperature lies
// outside the range or the range is empty.
// Fill writes every point in turn; bend and adapt rewrite the selected point and then
// each inner point, skipping the divider for each on a flat or inverted supply range.
// Synchronous active-low reset: registers to their reset values, every point reads 1.
// Depends on htca_pkg, htca_div and htca_mem.
`default_nettype none

module heating_curve_table_adapt import htca_pkg::*; #(
  parameter int POINTS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_beat_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_beat_t              out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [TEMP_W-1:0] cfg_data
);

  localparam int IW    = $clog2(POINTS);
  localparam int A_W   = 22;
  localparam int DEN_W = 23;
  localparam int DN_W  = 24;
  localparam int NUM_W = 32;

  typedef enum logic [19:0] {
    S_IDLE = 20'h00001,
    S_SEL  = 20'h00002,
    S_SELW = 20'h00004,
    S_RDX  = 20'h00008,
    S_CIDX = 20'h00010,
    S_DN   = 20'h00020,
    S_TBK  = 20'h00040,
    S_TBS  = 20'h00080,
    S_TBW  = 20'h00100,
    S_WR   = 20'h00200,
    S_NEXT = 20'h00400,
    S_RDI  = 20'h00800,
    S_P1   = 20'h01000,
    S_P2   = 20'h02000,
    S_SUM  = 20'h04000,
    S_FILL = 20'h08000,
    S_OUT  = 20'h10000,
    S_BS   = 20'h20000,
    S_BSW  = 20'h40000,
    S_DONE = 20'h80000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [TEMP_W-1:0] olo_r, ohi_r, slo_r, shi_r;
  in_beat_t                 in_r, in_nxt;
  logic [IW-1:0]            idx_r, idx_nxt;
  logic [IW-1:0]            i_r, i_nxt;
  logic [IW-1:0]            k_r, k_nxt;
  logic [IW-1:0]            w_r, w_nxt;
  logic [IW-1:0]            waddr_r, waddr_nxt;
  logic                     spread_r, spread_nxt;
  logic [BYTE_W-1:0]        cidx_r, cidx_nxt;
  logic [BYTE_W-1:0]        byte_r, byte_nxt;
  logic signed [A_W-1:0]    a_r, a_nxt;
  logic signed [DN_W-1:0]   dn_r, dn_nxt;
  logic signed [NUM_W-1:0]  p1_r, p1_nxt;
  logic signed [NUM_W-1:0]  p2_r, p2_nxt;
  logic signed [NUM_W-1:0]  num_r, num_nxt;
  logic signed [DEN_W-1:0]  den_r, den_nxt;
  logic                     neg_r, neg_nxt;
  logic [TEMP_W-1:0]        bsq_r, bsq_nxt;
  logic signed [TEMP_W-1:0] sup_r, sup_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_beat_t                out_data_r, out_data_nxt;

  div_req_t          dreq;
  div_rsp_t          drsp;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic              wr_en;
  logic [BYTE_W-1:0] rd_data;

  logic signed [12:0]       span;
  logic signed [12:0]       oden;
  logic [12:0]              toff;
  logic [BYTE_W-1:0]        mul_byte;
  logic signed [A_W-1:0]    prod_a;
  logic signed [DEN_W-1:0]  prod_k;
  logic signed [NUM_W-1:0]  prod_1;
  logic signed [NUM_W-1:0]  prod_2;
  logic signed [20:0]       tgt;
  logic signed [19:0]       dv;
  logic [A_W-1:0]           abs_a;
  logic [20:0]              bs_y;
  logic [41:0]              bs_prod;
  logic signed [13:0]       sup_full;
  logic [IW-1:0]            sel_idx;
  logic [BYTE_W-1:0]        fill_byte [POINTS];

  // Configuration registers, written only while idle
  assign cfg_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      olo_r <= OUTSIDE_LOW_RST;
      ohi_r <= OUTSIDE_HIGH_RST;
      slo_r <= SUPPLY_LOW_RST;
      shi_r <= SUPPLY_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OUTSIDE_LOW:  olo_r <= $signed(cfg_data);
        CFG_OUTSIDE_HIGH: ohi_r <= $signed(cfg_data);
        CFG_SUPPLY_LOW:   slo_r <= $signed(cfg_data);
        CFG_SUPPLY_HIGH:  shi_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Initial falling line, one constant byte per point
  for (genvar j = 0; j < POINTS; j++) begin : g_fill
    assign fill_byte[j] = BYTE_W'((510 * (POINTS - j) + POINTS) / (2 * POINTS));
  end

  // Spans and shared products
  assign span = $signed({shi_r[TEMP_W-1], shi_r}) - $signed({slo_r[TEMP_W-1], slo_r});
  assign oden = $signed({ohi_r[TEMP_W-1], ohi_r}) - $signed({olo_r[TEMP_W-1], olo_r});
  assign toff = 13'($signed({in_r.outside_temp[TEMP_W-1], in_r.outside_temp})
                    - $signed({olo_r[TEMP_W-1], olo_r}));

  assign mul_byte = (state_r == S_OUT) ? cidx_r : rd_data;
  assign prod_a   = $signed({1'b0, mul_byte}) * span;
  assign prod_k   = span * $signed({1'b0, k_r});
  assign prod_1   = a_r * $signed({1'b0, k_r});
  assign prod_2   = dn_r * $signed({1'b0, w_r});
  assign tgt      = ($signed({in_r.value[TEMP_W-1], in_r.value})
                     - $signed({slo_r[TEMP_W-1], slo_r})) * 21'sd255;
  assign dv       = in_r.value * 20'sd255;
  assign abs_a    = a_r[A_W-1] ? A_W'(-a_r) : A_W'(a_r);

  // Round |v| / 255 as (|v| + 127) / 255 by a shift-and-add reciprocal multiply,
  // exact over the full byte times span range
  assign bs_y     = abs_a[20:0] + 21'd127;
  assign bs_prod  = 42'(bs_y) + (42'(bs_y) << 4) + (42'(bs_y) << 12) + (42'(bs_y) << 20);
  assign sup_full = $signed({{2{slo_r[TEMP_W-1]}}, slo_r})
                    + (neg_r ? -$signed({2'b0, bsq_r}) : $signed({2'b0, bsq_r}));
  assign sel_idx  = (drsp.sat || drsp.quo > DIV_QW'(POINTS - 1))
                    ? IW'(POINTS - 1) : drsp.quo[IW-1:0];

  // Request sequencer
  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    idx_nxt       = idx_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    w_nxt         = w_r;
    waddr_nxt     = waddr_r;
    spread_nxt    = spread_r;
    cidx_nxt      = cidx_r;
    byte_nxt      = byte_r;
    a_nxt         = a_r;
    dn_nxt        = dn_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    neg_nxt       = neg_r;
    bsq_nxt       = bsq_r;
    sup_nxt       = sup_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    dreq          = '0;
    rd_en         = 1'b0;
    rd_addr       = idx_r;
    wr_en         = 1'b0;

    // Drop the result once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          state_nxt = S_SEL;
        end
      end
      // Map outside temperature to a point
      S_SEL: begin
        spread_nxt = 1'b0;
        i_nxt      = '0;
        if (in_r.outside_temp < olo_r) begin
          idx_nxt   = '0;
          state_nxt = (in_r.kind == KIND_FILL) ? S_FILL : S_RDX;
        end else if (in_r.outside_temp > ohi_r) begin
          idx_nxt   = IW'(POINTS - 1);
          state_nxt = (in_r.kind == KIND_FILL) ? S_FILL : S_RDX;
        end else if (oden <= 0) begin
          idx_nxt   = '0;
          state_nxt = (in_r.kind == KIND_FILL) ? S_FILL : S_RDX;
        end else begin
          dreq.start = 1'b1;
          dreq.num   = DIV_NW'(toff) * DIV_NW'(2 * POINTS) + DIV_NW'(oden);
          dreq.den   = DIV_DW'({oden, 1'b0});
          state_nxt  = S_SELW;
        end
      end
      S_SELW: begin
        if (drsp.done) begin
          idx_nxt   = sel_idx;
          state_nxt = (in_r.kind == KIND_FILL) ? S_FILL : S_RDX;
        end
      end
      S_RDX: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r;
        state_nxt = S_CIDX;
      end
      S_CIDX: begin
        cidx_nxt  = rd_data;
        a_nxt     = prod_a;
        state_nxt = (in_r.kind == KIND_LOOKUP) ? S_OUT : S_DN;
      end
      // Target position and change for the selected point
      S_DN: begin
        if (in_r.kind == KIND_BEND) begin
          dn_nxt  = DN_W'(tgt) - DN_W'(a_r);
          num_nxt = NUM_W'(tgt);
        end else begin
          dn_nxt  = DN_W'(dv);
          num_nxt = NUM_W'(a_r) + NUM_W'(dv);
        end
        k_nxt     = IW'(1);
        waddr_nxt = idx_r;
        state_nxt = S_TBK;
      end
      S_TBK: begin
        den_nxt   = prod_k;
        state_nxt = S_TBS;
      end
      // Round position to a byte, clamping at both ends
      S_TBS: begin
        if (span < 0) begin
          byte_nxt  = (num_r < 0) ? '0 : BYTE_MAX;
          state_nxt = S_WR;
        end else if (span == 0) begin
          byte_nxt  = (num_r > 0) ? BYTE_MAX : '0;
          state_nxt = S_WR;
        end else if (num_r < 0) begin
          byte_nxt  = '0;
          state_nxt = S_WR;
        end else begin
          dreq.start = 1'b1;
          dreq.num   = DIV_NW'({num_r[NUM_W-2:0], 1'b0}) + DIV_NW'(den_r);
          dreq.den   = DIV_DW'({den_r, 1'b0});
          state_nxt  = S_TBW;
        end
      end
      S_TBW: begin
        if (drsp.done) begin
          byte_nxt  = (drsp.sat || drsp.quo > DIV_QW'(BYTE_MAX))
                      ? BYTE_MAX : drsp.quo[BYTE_W-1:0];
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        wr_en = 1'b1;
        if (waddr_r == idx_r) begin
          cidx_nxt = byte_r;
        end
        if (in_r.kind == KIND_FILL) begin
          if (i_r == IW'(POINTS - 1)) begin
            state_nxt = S_OUT;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_FILL;
          end
        end else begin
          if (!spread_r) begin
            spread_nxt = 1'b1;
            i_nxt      = IW'(1);
          end else begin
            i_nxt = i_r + 1'b1;
          end
          state_nxt = S_NEXT;
        end
      end
      // Walk the inner points, skipping the selected one
      S_NEXT: begin
        if (i_r == IW'(POINTS - 1)) begin
          state_nxt = S_OUT;
        end else if (i_r == idx_r) begin
          i_nxt = i_r + 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = i_r;
          if (i_r < idx_r) begin
            k_nxt = idx_r;
            w_nxt = i_r;
          end else begin
            k_nxt = IW'(POINTS - 1) - idx_r;
            w_nxt = IW'(POINTS - 1) - i_r;
          end
          state_nxt = S_RDI;
        end
      end
      S_RDI: begin
        a_nxt     = prod_a;
        waddr_nxt = i_r;
        state_nxt = S_P1;
      end
      S_P1: begin
        p1_nxt    = prod_1;
        state_nxt = S_P2;
      end
      S_P2: begin
        p2_nxt    = prod_2;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        num_nxt   = p1_r + p2_r;
        state_nxt = S_TBK;
      end
      // Initial falling line, or all zero on a flat or inverted supply range
      S_FILL: begin
        waddr_nxt = i_r;
        byte_nxt  = (span <= 0) ? '0 : fill_byte[i_r];
        state_nxt = S_WR;
      end
      // Convert the selected byte back to a temperature
      S_OUT: begin
        a_nxt     = prod_a;
        state_nxt = S_BS;
      end
      S_BS: begin
        neg_nxt   = a_r[A_W-1];
        bsq_nxt   = bs_prod[39:28];
        state_nxt = S_BSW;
      end
      S_BSW: begin
        sup_nxt   = sup_full[TEMP_W-1:0];
        state_nxt = S_DONE;
      end
      // Hold until the output register is free
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.supply_temp = sup_r;
          out_data_nxt.point_index = PIDX_W'(idx_r);
          out_data_nxt.stored_byte = cidx_r;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      spread_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      spread_r    <= spread_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    idx_r      <= idx_nxt;
    i_r        <= i_nxt;
    k_r        <= k_nxt;
    w_r        <= w_nxt;
    waddr_r    <= waddr_nxt;
    cidx_r     <= cidx_nxt;
    byte_r     <= byte_nxt;
    a_r        <= a_nxt;
    dn_r       <= dn_nxt;
    p1_r       <= p1_nxt;
    p2_r       <= p2_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    neg_r      <= neg_nxt;
    bsq_r      <= bsq_nxt;
    sup_r      <= sup_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  htca_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  htca_mem #(
    .POINTS (POINTS),
    .IW     (IW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (waddr_r),
    .wr_data (byte_r),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire
